[hw/rtl/bqsg_pkg.sv]
// Shared types, widths and constants of the biquad low-pass with smoothed gain.
// Used by the controller, the datapath, the top level and the port checker.
// Depends on nothing.
`default_nettype none

package bqsg_pkg;

  localparam int SAMPLE_W     = 24;
  localparam int COEF_W       = 26;
  localparam int GAIN_W       = 24;
  localparam int CHAN_W       = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 26;
  localparam int CHANNELS_DEF = 8;

  // Smoothing factor 0.002 in Q0.24, rounded.
  localparam int SMOOTH_K     = 33554;
  // Unity gain in Q1.23; also the reset value of every channel's gain.
  localparam int GAIN_UNITY   = 8388608;
  // Coefficient b0 resets to 1.0 in Q3.22.
  localparam int COEF_ONE     = 4194304;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_EFFECT_ON   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B0     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B1     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B2     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A1     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A2     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_GAIN = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAC0,
    S_MAC1,
    S_MAC2,
    S_MAC3,
    S_MAC4,
    S_GSTEP,
    S_ROUND,
    S_SCALE,
    S_FIN
  } state_t;

  // Operand pair presented to the shared multiplier.
  typedef enum logic [2:0] {
    MS_B0X,
    MS_B1X1,
    MS_B2X2,
    MS_A1Y1,
    MS_A2Y2,
    MS_GSTEP,
    MS_SCALE
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef struct packed {
    logic     in_load;
    logic     mul_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     round_en;
    logic     state_wr;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic bypass;
  } status_t;

endpackage

`default_nettype wire

[hw/rtl/bqsg_ctrl.sv]
// Sequencer of the biquad with smoothed gain: steps one word through the
// shared multiplier and owns the handshake state. Depends on bqsg_pkg.
`default_nettype none

module bqsg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire bqsg_pkg::status_t status,
  output bqsg_pkg::cmd_t         cmd
);

  bqsg_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == bqsg_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bqsg_pkg::S_IDLE:  if (in_tvalid) state_nxt = bqsg_pkg::S_MAC0;
      bqsg_pkg::S_MAC0:  state_nxt = status.bypass ? bqsg_pkg::S_FIN : bqsg_pkg::S_MAC1;
      bqsg_pkg::S_MAC1:  state_nxt = bqsg_pkg::S_MAC2;
      bqsg_pkg::S_MAC2:  state_nxt = bqsg_pkg::S_MAC3;
      bqsg_pkg::S_MAC3:  state_nxt = bqsg_pkg::S_MAC4;
      bqsg_pkg::S_MAC4:  state_nxt = bqsg_pkg::S_GSTEP;
      bqsg_pkg::S_GSTEP: state_nxt = bqsg_pkg::S_ROUND;
      bqsg_pkg::S_ROUND: state_nxt = bqsg_pkg::S_SCALE;
      bqsg_pkg::S_SCALE: state_nxt = bqsg_pkg::S_FIN;
      bqsg_pkg::S_FIN:   if (out_free) state_nxt = bqsg_pkg::S_IDLE;
      default:           state_nxt = bqsg_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = bqsg_pkg::MS_B0X;
    cmd.acc_op   = bqsg_pkg::ACC_HOLD;
    unique case (state_r)
      bqsg_pkg::S_IDLE: cmd.in_load = in_tvalid;
      bqsg_pkg::S_MAC0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = bqsg_pkg::MS_B0X;
      end
      bqsg_pkg::S_MAC1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = bqsg_pkg::MS_B1X1;
        cmd.acc_op  = bqsg_pkg::ACC_LOAD;
      end
      bqsg_pkg::S_MAC2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = bqsg_pkg::MS_B2X2;
        cmd.acc_op  = bqsg_pkg::ACC_ADD;
      end
      bqsg_pkg::S_MAC3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = bqsg_pkg::MS_A1Y1;
        cmd.acc_op  = bqsg_pkg::ACC_ADD;
      end
      bqsg_pkg::S_MAC4: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = bqsg_pkg::MS_A2Y2;
        cmd.acc_op  = bqsg_pkg::ACC_SUB;
      end
      bqsg_pkg::S_GSTEP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = bqsg_pkg::MS_GSTEP;
        cmd.acc_op  = bqsg_pkg::ACC_SUB;
      end
      bqsg_pkg::S_ROUND: cmd.round_en = 1'b1;
      bqsg_pkg::S_SCALE: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = bqsg_pkg::MS_SCALE;
        cmd.state_wr = 1'b1;
      end
      bqsg_pkg::S_FIN: cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bqsg_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bqsg_dp.sv]
// Datapath of the biquad with smoothed gain: configuration registers, per-channel
// filter and gain state, one shared multiplier, accumulator and output register.
// Depends on bqsg_pkg; driven by bqsg_ctrl.
`default_nettype none

module bqsg_dp #(
  parameter int CHANNELS = bqsg_pkg::CHANNELS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [bqsg_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  wire logic [bqsg_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic [bqsg_pkg::CHAN_W-1:0]         in_chan,
  input  wire logic [bqsg_pkg::SAMPLE_W-1:0]       in_sample,
  input  wire bqsg_pkg::cmd_t                      cmd,
  output bqsg_pkg::status_t                        status,
  output logic [bqsg_pkg::SAMPLE_W-1:0]            out_sample
);

  localparam int SW     = bqsg_pkg::SAMPLE_W;
  localparam int CW     = bqsg_pkg::COEF_W;
  localparam int GW     = bqsg_pkg::GAIN_W;
  localparam int MA_W   = CW;
  localparam int MB_W   = SW + 1;
  localparam int PROD_W = MA_W + MB_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic signed [ACC_W-1:0]  SAT_HI  = ACC_W'((2 ** (SW - 1)) - 1);
  localparam logic signed [ACC_W-1:0]  SAT_LO  = ACC_W'(-(2 ** (SW - 1)));
  localparam logic signed [ACC_W-1:0]  RND_Y   = ACC_W'(2 ** 21);
  localparam logic signed [ACC_W-1:0]  RND_OUT = ACC_W'(2 ** 22);
  localparam logic signed [PROD_W-1:0] RND_G   = PROD_W'(2 ** 23);

  function automatic logic signed [SW-1:0] sat_smp(input logic signed [ACC_W-1:0] v);
    logic signed [SW-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[SW-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SW-1:0];
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic                   effect_on_r;
  logic signed [CW-1:0]   coef_b0_r, coef_b1_r, coef_b2_r, coef_a1_r, coef_a2_r;
  logic        [GW-1:0]   target_gain_r;

  // Current word.
  logic signed [SW-1:0]                x_r;
  logic        [bqsg_pkg::CHAN_W-1:0]  chan_r;
  logic                                bypass_r;
  logic                                in_range;
  logic        [IDX_W-1:0]             idx;

  // Per-channel state.
  logic signed [SW-1:0] xd1_r [CHANNELS];
  logic signed [SW-1:0] xd2_r [CHANNELS];
  logic signed [SW-1:0] yd1_r [CHANNELS];
  logic signed [SW-1:0] yd2_r [CHANNELS];
  logic        [GW-1:0] gain_r [CHANNELS];

  logic signed [SW-1:0] xd1, xd2, yd1, yd2;
  logic        [GW-1:0] g_cur;

  // Arithmetic.
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [GW:0]       gdiff;
  logic signed [ACC_W-1:0]  y_full;
  logic signed [PROD_W-1:0] g_step;
  logic signed [PROD_W-1:0] g_sum;
  logic signed [ACC_W-1:0]  o_full;
  logic signed [SW-1:0]     y_r;
  logic        [GW-1:0]     g_new_r;
  logic        [SW-1:0]     out_sample_r;

  assign in_range      = (32'(in_chan) < CHANNELS);
  assign idx           = IDX_W'(chan_r);
  assign status.bypass = bypass_r;
  assign out_sample    = out_sample_r;

  assign xd1   = xd1_r[idx];
  assign xd2   = xd2_r[idx];
  assign yd1   = yd1_r[idx];
  assign yd2   = yd2_r[idx];
  assign g_cur = gain_r[idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      effect_on_r   <= 1'b0;
      coef_b0_r     <= CW'(bqsg_pkg::COEF_ONE);
      coef_b1_r     <= '0;
      coef_b2_r     <= '0;
      coef_a1_r     <= '0;
      coef_a2_r     <= '0;
      target_gain_r <= GW'(bqsg_pkg::GAIN_UNITY);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        bqsg_pkg::REG_EFFECT_ON:   effect_on_r   <= cfg_data[0];
        bqsg_pkg::REG_COEF_B0:     coef_b0_r     <= cfg_data[CW-1:0];
        bqsg_pkg::REG_COEF_B1:     coef_b1_r     <= cfg_data[CW-1:0];
        bqsg_pkg::REG_COEF_B2:     coef_b2_r     <= cfg_data[CW-1:0];
        bqsg_pkg::REG_COEF_A1:     coef_a1_r     <= cfg_data[CW-1:0];
        bqsg_pkg::REG_COEF_A2:     coef_a2_r     <= cfg_data[CW-1:0];
        bqsg_pkg::REG_TARGET_GAIN: target_gain_r <= cfg_data[GW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r <= 1'b1;
    end else if (cmd.in_load) begin
      bypass_r <= !effect_on_r || !in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      x_r    <= in_sample;
      chan_r <= in_chan;
    end
  end

  // Gain difference fits 25 bits signed; the target may sit above unity.
  assign gdiff = signed'({1'b0, target_gain_r}) - signed'({1'b0, g_cur});

  always_comb begin
    case (cmd.mul_sel)
      bqsg_pkg::MS_B0X: begin
        mul_a = coef_b0_r;
        mul_b = MB_W'(x_r);
      end
      bqsg_pkg::MS_B1X1: begin
        mul_a = coef_b1_r;
        mul_b = MB_W'(xd1);
      end
      bqsg_pkg::MS_B2X2: begin
        mul_a = coef_b2_r;
        mul_b = MB_W'(xd2);
      end
      bqsg_pkg::MS_A1Y1: begin
        mul_a = coef_a1_r;
        mul_b = MB_W'(yd1);
      end
      bqsg_pkg::MS_A2Y2: begin
        mul_a = coef_a2_r;
        mul_b = MB_W'(yd2);
      end
      bqsg_pkg::MS_GSTEP: begin
        mul_a = MA_W'(gdiff);
        mul_b = MB_W'(bqsg_pkg::SMOOTH_K);
      end
      bqsg_pkg::MS_SCALE: begin
        mul_a = MA_W'(y_r);
        mul_b = signed'({1'b0, g_new_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.acc_op)
      bqsg_pkg::ACC_LOAD: acc_r <= ACC_W'(prod_r);
      bqsg_pkg::ACC_ADD:  acc_r <= acc_r + ACC_W'(prod_r);
      bqsg_pkg::ACC_SUB:  acc_r <= acc_r - ACC_W'(prod_r);
      default:            acc_r <= acc_r;
    endcase
  end

  // Filter output: Q.45 sum back to Q1.23 with round half up, then saturate.
  assign y_full = (acc_r + RND_Y) >>> 22;
  // Gain step: difference times 0.002, rounded; it never overshoots the target.
  assign g_step = (prod_r + RND_G) >>> 24;
  assign g_sum  = PROD_W'(signed'({1'b0, g_cur})) + g_step;
  // Output: filter output times gain, Q1.23 with round half up.
  assign o_full = (ACC_W'(prod_r) + RND_OUT) >>> 23;

  always_ff @(posedge clk) begin
    if (cmd.round_en) begin
      y_r     <= sat_smp(y_full);
      g_new_r <= g_sum[GW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        xd1_r[i]  <= '0;
        xd2_r[i]  <= '0;
        yd1_r[i]  <= '0;
        yd2_r[i]  <= '0;
        gain_r[i] <= GW'(bqsg_pkg::GAIN_UNITY);
      end
    end else if (cmd.state_wr) begin
      xd2_r[idx]  <= xd1;
      xd1_r[idx]  <= x_r;
      yd2_r[idx]  <= yd1;
      yd1_r[idx]  <= y_r;
      gain_r[idx] <= g_new_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sample_r <= bypass_r ? x_r : sat_smp(o_full);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/biquad_lowpass_smoothed_gain.sv]
// Top level of the per-channel biquad low-pass with one-pole gain smoother.
// Instantiates bqsg_ctrl and bqsg_dp; depends on bqsg_pkg.
//
// Each input word carries one signed Q1.23 sample and its channel number. With
// effect_on set and the channel below CHANNELS, the sample runs through that
// channel's direct form I biquad (coefficients b0, b1, b2, a1, a2 in Q3.22, the
// a terms subtracted), the channel's gain moves toward target_gain by 0.002 of
// the difference, and the filter output times the new gain, saturated to 24
// bits, leaves as one output word. Otherwise the sample passes unchanged and no
// channel state moves. A filtered word steps through MAC0 to MAC4, GSTEP, ROUND,
// SCALE and FIN before the next word can be taken, a passed-through word through
// MAC0 and FIN; the steps come from the single shared 26 x 25 bit multiplier,
// which serves the five filter taps, the gain step and the output scaling in
// turn. The result sits in an output register, so the next word is accepted
// while a finished one still waits on out_tready. Configuration registers are
// written through cfg_we/cfg_idx/cfg_data and should only change while no word
// is in flight. Reset restores the configuration registers and clears every
// channel's delay line, with each channel's gain set to unity.
`default_nettype none

module biquad_lowpass_smoothed_gain #(
  parameter int CHANNELS = bqsg_pkg::CHANNELS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Configuration write port.
  input  wire logic                              cfg_we,
  input  wire logic [bqsg_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [bqsg_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Input stream.
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [bqsg_pkg::SAMPLE_W-1:0]     in_tdata,   // [23:0] sample_in
  input  wire logic [bqsg_pkg::CHAN_W-1:0]       in_tuser,   // [2:0] chan
  // Output stream.
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [bqsg_pkg::SAMPLE_W-1:0]          out_tdata   // [23:0] sample_out
);

  // Commands from the sequencer and status back from the datapath.
  bqsg_pkg::cmd_t    cmd;
  bqsg_pkg::status_t status;

  bqsg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  bqsg_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .in_chan    (in_tuser),
    .in_sample  (in_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_sample (out_tdata)
  );

endmodule

`default_nettype wire

[hw/rtl/bqsg_checker.sv]
// Port-level checks of the biquad with smoothed gain, and the bind that
// attaches them to the top level. Depends on bqsg_pkg.
`default_nettype none

module bqsg_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tvalid,
  input wire logic                          in_tready,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [bqsg_pkg::SAMPLE_W-1:0] out_tdata
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word valid right after reset");

  // A waiting output word holds its value until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word dropped or changed while stalled");

  // One word at a time: the input closes right after an acceptance.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word accepted while one is in flight");

  // No result can appear in the cycle right after an acceptance.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("output word appeared too early");

endmodule

bind biquad_lowpass_smoothed_gain bqsg_checker u_bqsg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
